FILE: rtl/tsg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the sine table builder for the turtle segment generator.
package tsg_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int STACK_DEPTH_DEF = 64;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_HEADING = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TURN_ANGLE = 2'd1;

	localparam logic [1:0] STATUS_SEGMENT = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

	localparam logic [23:0] STEP_ONE = 24'd65536;

	typedef enum logic [3:0] {
		OP_START   = 4'd0,
		OP_PLUS    = 4'd1,
		OP_MINUS   = 4'd2,
		OP_MOVE    = 4'd3,
		OP_DRAW    = 4'd4,
		OP_PUSH    = 4'd5,
		OP_POP     = 4'd6,
		OP_REVERSE = 4'd7,
		OP_SETCOL  = 4'd8,
		OP_ADDCOL  = 4'd9,
		OP_SCALE   = 4'd10,
		OP_TURNDEG = 4'd11
	} opcode_t;

	typedef logic [ANGLE_BITS-1:0] heading_t;

	typedef struct packed {
		heading_t    heading;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [23:0] step;
		logic        neg;
		logic [7:0]  color;
	} turtle_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stack_op_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stack_stat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] start_x;
		logic [31:0] start_y;
		logic [31:0] end_x;
		logic [31:0] end_y;
		logic [7:0]  color;
	} res_t;

	// Degree handling. A full circle is 360 degrees; the operand is reduced
	// modulo 360 by a reciprocal multiply that is exact over 24 bits.
	localparam int DEG_FULL = 360;
	localparam int MOD_SHIFT = 33;
	localparam longint MOD_M = ((64'd1 << MOD_SHIFT) + DEG_FULL - 1) / DEG_FULL;
	localparam int MOD_OFFSET = (1 << 23) % DEG_FULL;

	// Heading increment = r * DEG_Q + floor((r * DEG_R + 180) / 360).
	localparam int DEG_SHIFT = 26;
	localparam longint DEG_Q = (64'd1 << ANGLE_BITS) / DEG_FULL;
	localparam longint DEG_R = (64'd1 << ANGLE_BITS) % DEG_FULL;
	localparam longint DEG_M = ((64'd1 << DEG_SHIFT) + DEG_FULL - 1) / DEG_FULL;
	localparam longint DEG_RM = DEG_R * DEG_M;
	localparam longint DEG_HALF = (DEG_FULL / 2) * DEG_M;

	localparam int H12_SHIFT = (ANGLE_BITS >= 12) ? ANGLE_BITS - 12 : 0;
	localparam int H12_PAD = (ANGLE_BITS < 12) ? 12 - ANGLE_BITS : 0;

	localparam int QTAB_LAST = 1024;
	typedef logic [16:0] qtab_t [0:QTAB_LAST];

	function automatic logic [11:0] heading_to_h12(heading_t h);
		return 12'((32'(h) >> H12_SHIFT) << H12_PAD);
	endfunction

	// Quarter-wave sine in Q1.16 from an odd polynomial, clamped to 1.0.
	function automatic qtab_t build_qtab();
		qtab_t  tab;
		longint t;
		longint t2;
		longint p;
		longint s;
		for (int k = 0; k <= QTAB_LAST; k++) begin
			t = longint'(k) <<< 20;
			t2 = (t * t) >>> 30;
			p = 64'sd172272;
			p = 64'sd5026998 - ((t2 * p) >>> 30);
			p = 64'sd85569305 - ((t2 * p) >>> 30);
			p = 64'sd693598668 - ((t2 * p) >>> 30);
			p = 64'sd1686629713 - ((t2 * p) >>> 30);
			s = (((t * p) >>> 30) + 64'sd8192) >>> 14;
			tab[k] = (s > 64'sd65536) ? 17'd65536 : 17'(s);
		end
		return tab;
	endfunction

endpackage

FILE: rtl/tsg_trig_rom.sv
`timescale 1ns / 1ps
// Sine and cosine lookup with registered read, addressed by the next heading.
module tsg_trig_rom (
	input  logic                clk,
	input  logic                arst_n,
	input  tsg_pkg::heading_t   heading,
	output logic signed [17:0]  cos_val,
	output logic signed [17:0]  sin_val
);

	localparam tsg_pkg::qtab_t QTAB = tsg_pkg::build_qtab();

	logic [11:0] h12_sin;
	logic [11:0] h12_cos;
	logic [10:0] idx_sin;
	logic [10:0] idx_cos;
	logic [16:0] sin_mag_q;
	logic [16:0] cos_mag_q;
	logic        sin_neg_q;
	logic        cos_neg_q;

	always_comb begin
		h12_sin = tsg_pkg::heading_to_h12(heading);
		h12_cos = h12_sin + 12'd1024;
		idx_sin = h12_sin[10] ? 11'(tsg_pkg::QTAB_LAST) - {1'b0, h12_sin[9:0]}
			: {1'b0, h12_sin[9:0]};
		idx_cos = h12_cos[10] ? 11'(tsg_pkg::QTAB_LAST) - {1'b0, h12_cos[9:0]}
			: {1'b0, h12_cos[9:0]};
	end

	// The reset values match a heading of zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_mag_q <= QTAB[0];
			cos_mag_q <= QTAB[tsg_pkg::QTAB_LAST];
			sin_neg_q <= 1'b0;
			cos_neg_q <= 1'b0;
		end else begin
			sin_mag_q <= QTAB[idx_sin];
			cos_mag_q <= QTAB[idx_cos];
			sin_neg_q <= h12_sin[11];
			cos_neg_q <= h12_cos[11];
		end
	end

	assign sin_val = sin_neg_q ? -$signed({1'b0, sin_mag_q}) : $signed({1'b0, sin_mag_q});
	assign cos_val = cos_neg_q ? -$signed({1'b0, cos_mag_q}) : $signed({1'b0, cos_mag_q});

endmodule

FILE: rtl/tsg_stack.sv
`timescale 1ns / 1ps
// Branch stack: top entry and next entry in registers, deeper entries in a memory.
module tsg_stack #(
	parameter int STACK_DEPTH = tsg_pkg::STACK_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsg_pkg::stack_op_t    op,
	input  tsg_pkg::turtle_t      push_data,
	output tsg_pkg::turtle_t      top,
	output tsg_pkg::stack_stat_t  stat
);

	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	tsg_pkg::turtle_t mem [STACK_DEPTH];
	tsg_pkg::turtle_t top_q;
	tsg_pkg::turtle_t mem_rd_q;
	tsg_pkg::turtle_t byp_data_q;
	tsg_pkg::turtle_t below;
	logic             byp_q;
	logic [LVL_W-1:0] level_q;
	logic [LVL_W-1:0] wr_lvl;
	logic [LVL_W-1:0] rd_lvl;

	// Entry level-1 lives in top_q, entry level-2 in below, the rest in mem.
	assign below = byp_q ? byp_data_q : mem_rd_q;
	assign wr_lvl = level_q - LVL_W'(1);
	assign rd_lvl = level_q - LVL_W'(3);

	always_ff @(posedge clk) begin
		if (op.push && (level_q != '0)) begin
			mem[wr_lvl[ADDR_W-1:0]] <= top_q;
		end
		if (op.pop) begin
			mem_rd_q <= mem[rd_lvl[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			top_q <= push_data;
			byp_data_q <= top_q;
		end else if (op.pop) begin
			top_q <= below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			byp_q <= 1'b0;
		end else if (op.clear) begin
			level_q <= '0;
			byp_q <= 1'b0;
		end else if (op.push) begin
			level_q <= level_q + LVL_W'(1);
			byp_q <= 1'b1;
		end else if (op.pop) begin
			level_q <= level_q - LVL_W'(1);
			byp_q <= 1'b0;
		end
	end

	assign top = top_q;
	assign stat.empty = (level_q == '0);
	assign stat.full = (level_q == LVL_W'(STACK_DEPTH));

endmodule

FILE: rtl/tsg_exec.sv
`timescale 1ns / 1ps
// Command execution: next turtle state, stack operation and result for one command.
module tsg_exec (
	input  logic [3:0]            opcode,
	input  logic signed [23:0]    operand_value,
	input  logic [8:0]            deg_pos,
	input  logic [8:0]            deg_neg,
	input  tsg_pkg::turtle_t      cur,
	input  tsg_pkg::turtle_t      top,
	input  tsg_pkg::stack_stat_t  stk,
	input  logic signed [17:0]    cos_val,
	input  logic signed [17:0]    sin_val,
	input  logic [15:0]           initial_heading,
	input  logic [15:0]           turn_angle,
	output tsg_pkg::turtle_t      nxt,
	output tsg_pkg::stack_op_t    stk_op,
	output logic                  res_valid,
	output tsg_pkg::res_t         res
);

	function automatic logic [31:0] sat32(logic [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		return v[31:0];
	endfunction

	tsg_pkg::opcode_t    opc;
	logic signed [41:0]  prod_x;
	logic signed [41:0]  prod_y;
	logic [41:0]         rnd_x;
	logic [41:0]         rnd_y;
	logic [25:0]         dx;
	logic [25:0]         dy;
	logic [31:0]         adv_x;
	logic [31:0]         adv_y;
	logic signed [47:0]  prod_s;
	logic [47:0]         rnd_s;
	logic [31:0]         sc;
	logic [23:0]         step_sc;
	tsg_pkg::heading_t   ta;
	logic [8:0]          deg_r;
	logic [39:0]         deg_frac;
	tsg_pkg::heading_t   deg_inc;

	always_comb begin
		prod_x = $signed(cur.step) * cos_val;
		prod_y = $signed(cur.step) * sin_val;
		rnd_x = prod_x + 42'sd32768;
		rnd_y = prod_y + 42'sd32768;
		dx = rnd_x[41:16];
		dy = rnd_y[41:16];
		adv_x = sat32({cur.pos_x[31], cur.pos_x} + {{7{dx[25]}}, dx});
		adv_y = sat32({cur.pos_y[31], cur.pos_y} + {{7{dy[25]}}, dy});

		prod_s = $signed(cur.step) * operand_value;
		rnd_s = prod_s + 48'sd32768;
		sc = rnd_s[47:16];
		if ((&sc[31:23]) || !(|sc[31:23])) begin
			step_sc = sc[23:0];
		end else begin
			step_sc = sc[31] ? 24'h80_0000 : 24'h7f_ffff;
		end

		ta = tsg_pkg::heading_t'(turn_angle);
		deg_r = cur.neg ? deg_neg : deg_pos;
		deg_frac = 40'(deg_r) * 40'(tsg_pkg::DEG_RM) + 40'(tsg_pkg::DEG_HALF);
		deg_inc = tsg_pkg::heading_t'(40'(deg_r) * 40'(tsg_pkg::DEG_Q)
			+ (deg_frac >> tsg_pkg::DEG_SHIFT));
	end

	always_comb begin
		opc = tsg_pkg::opcode_t'(opcode);
		nxt = cur;
		stk_op = '0;
		res_valid = 1'b0;
		res = '0;
		unique case (opc)
			tsg_pkg::OP_START: begin
				nxt.heading = tsg_pkg::heading_t'(initial_heading);
				nxt.pos_x = '0;
				nxt.pos_y = '0;
				nxt.step = tsg_pkg::STEP_ONE;
				nxt.neg = 1'b0;
				nxt.color = '0;
				stk_op.clear = 1'b1;
			end
			tsg_pkg::OP_PLUS, tsg_pkg::OP_MINUS: begin
				if ((opc == tsg_pkg::OP_MINUS) != cur.neg) begin
					nxt.heading = cur.heading - ta;
				end else begin
					nxt.heading = cur.heading + ta;
				end
			end
			tsg_pkg::OP_MOVE: begin
				nxt.pos_x = adv_x;
				nxt.pos_y = adv_y;
			end
			tsg_pkg::OP_DRAW: begin
				nxt.pos_x = adv_x;
				nxt.pos_y = adv_y;
				res_valid = 1'b1;
				res.status = tsg_pkg::STATUS_SEGMENT;
				res.start_x = cur.pos_x;
				res.start_y = cur.pos_y;
				res.end_x = adv_x;
				res.end_y = adv_y;
				res.color = cur.color;
			end
			tsg_pkg::OP_PUSH: begin
				if (stk.full) begin
					res_valid = 1'b1;
					res.status = tsg_pkg::STATUS_OVERFLOW;
				end else begin
					stk_op.push = 1'b1;
				end
			end
			tsg_pkg::OP_POP: begin
				if (stk.empty) begin
					res_valid = 1'b1;
					res.status = tsg_pkg::STATUS_UNDERFLOW;
				end else begin
					stk_op.pop = 1'b1;
					nxt = top;
				end
			end
			tsg_pkg::OP_REVERSE: begin
				nxt.neg = !cur.neg;
			end
			tsg_pkg::OP_SETCOL: begin
				nxt.color = operand_value[7:0];
			end
			tsg_pkg::OP_ADDCOL: begin
				nxt.color = cur.color + operand_value[7:0];
			end
			tsg_pkg::OP_SCALE: begin
				nxt.step = step_sc;
			end
			tsg_pkg::OP_TURNDEG: begin
				nxt.heading = cur.heading + deg_inc;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

FILE: rtl/turtle_segment_generator_core.sv
`timescale 1ns / 1ps
// Top level of the turtle segment generator: input stage, turtle state, result register.
// Throughput: one command per cycle. The turtle state loop (table read, one multiply,
// saturating add) closes on the turtle state register, and a command word is accepted
// while a result waits unless the command ahead of it also makes a result.
// A command is held in the input stage register until it executes; its result word is
// registered as it executes and offered from the next cycle on. Reset clears the turtle
// to its start state and empties the stack; stack memory needs no clearing pass.
module turtle_segment_generator_core #(
	parameter int STACK_DEPTH = tsg_pkg::STACK_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_stall,
	input  logic [3:0]                       opcode,
	input  logic signed [23:0]               operand_value,
	output logic                             seg_valid,
	input  logic                             seg_stall,
	output logic [1:0]                       status,
	output logic signed [31:0]               start_x,
	output logic signed [31:0]               start_y,
	output logic signed [31:0]               end_x,
	output logic signed [31:0]               end_y,
	output logic [7:0]                       segment_color,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tsg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [15:0]                      cfg_data
);

	logic [15:0]           init_heading_q;
	logic [15:0]           turn_angle_q;

	logic [23:0]           deg_u;
	logic [48:0]           deg_prod;
	logic [15:0]           deg_quo;
	logic [23:0]           deg_rem_w;
	logic [8:0]            deg_rem;
	logic [8:0]            deg_pos;
	logic [8:0]            deg_neg;

	logic                  valid_s1;
	logic [3:0]            op_s1;
	logic signed [23:0]    operand_s1;
	logic [8:0]            deg_pos_s1;
	logic [8:0]            deg_neg_s1;

	tsg_pkg::turtle_t      cur_q;
	tsg_pkg::turtle_t      nxt;
	tsg_pkg::turtle_t      stk_top;
	tsg_pkg::stack_stat_t  stk_stat;
	tsg_pkg::stack_op_t    stk_op;
	tsg_pkg::stack_op_t    stk_op_fire;
	tsg_pkg::heading_t     heading_nx;
	logic signed [17:0]    cos_val;
	logic signed [17:0]    sin_val;
	logic                  res_valid;
	tsg_pkg::res_t         res;
	tsg_pkg::res_t         res_q;
	logic                  seg_valid_q;
	logic                  fire;
	logic                  accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_heading_q <= '0;
			turn_angle_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tsg_pkg::CFG_INITIAL_HEADING: init_heading_q <= cfg_data;
				tsg_pkg::CFG_TURN_ANGLE: turn_angle_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Reduce the operand modulo 360 ahead of the input register, for both turn signs.
	always_comb begin
		deg_u = {~operand_value[23], operand_value[22:0]};
		deg_prod = 49'(deg_u) * 49'(tsg_pkg::MOD_M);
		deg_quo = deg_prod[tsg_pkg::MOD_SHIFT +: 16];
		deg_rem_w = deg_u - 24'(deg_quo) * 24'(tsg_pkg::DEG_FULL);
		deg_rem = deg_rem_w[8:0];
		if (deg_rem >= 9'(tsg_pkg::MOD_OFFSET)) begin
			deg_pos = deg_rem - 9'(tsg_pkg::MOD_OFFSET);
		end else begin
			deg_pos = deg_rem + 9'(tsg_pkg::DEG_FULL - tsg_pkg::MOD_OFFSET);
		end
		deg_neg = (deg_pos == '0) ? '0 : 9'(tsg_pkg::DEG_FULL) - deg_pos;
	end

	assign fire = valid_s1 && (!res_valid || !seg_valid_q || !seg_stall);
	assign cmd_stall = valid_s1 && !fire;
	assign accept = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= opcode;
			operand_s1 <= operand_value;
			deg_pos_s1 <= deg_pos;
			deg_neg_s1 <= deg_neg;
		end
	end

	tsg_exec u_exec (
		.opcode          (op_s1),
		.operand_value   (operand_s1),
		.deg_pos         (deg_pos_s1),
		.deg_neg         (deg_neg_s1),
		.cur             (cur_q),
		.top             (stk_top),
		.stk             (stk_stat),
		.cos_val         (cos_val),
		.sin_val         (sin_val),
		.initial_heading (init_heading_q),
		.turn_angle      (turn_angle_q),
		.nxt             (nxt),
		.stk_op          (stk_op),
		.res_valid       (res_valid),
		.res             (res)
	);

	assign stk_op_fire = fire ? stk_op : '0;

	tsg_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (stk_op_fire),
		.push_data (cur_q),
		.top       (stk_top),
		.stat      (stk_stat)
	);

	assign heading_nx = fire ? nxt.heading : cur_q.heading;

	tsg_trig_rom u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.heading (heading_nx),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '{heading: '0, pos_x: '0, pos_y: '0, step: tsg_pkg::STEP_ONE,
				neg: 1'b0, color: '0};
		end else if (fire) begin
			cur_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			seg_valid_q <= 1'b1;
		end else if (!seg_stall) begin
			seg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			res_q <= res;
		end
	end

	assign seg_valid = seg_valid_q;
	assign status = res_q.status;
	assign start_x = res_q.start_x;
	assign start_y = res_q.start_y;
	assign end_x = res_q.end_x;
	assign end_y = res_q.end_y;
	assign segment_color = res_q.color;

endmodule

FILE: tb/tb_turtle_segment_generator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for turtle_segment_generator_core: directed table and random streams.
module tb_turtle_segment_generator_core;

	localparam logic [3:0] OP_IGNORED_LO = 4'd12;
	localparam logic [3:0] OP_IGNORED_HI = 4'd15;
	localparam int STACK_LEVELS = tsg_pkg::STACK_DEPTH_DEF;
	localparam int FULL_CIRCLE = 360;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		tsg_pkg::heading_t heading;
		int       px;
		int       py;
		int       step;
		bit       neg;
		logic [7:0] color;
	} pose_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] sx;
		logic [31:0] sy;
		logic [31:0] ex;
		logic [31:0] ey;
		logic [7:0]  color;
	} seg_word_t;

	typedef struct {
		logic [3:0]  op;
		logic [23:0] arg;
		bit          typed;
		seg_word_t   want;
	} row_t;

	localparam seg_word_t NO_WORD = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	logic [3:0] opcode;
	logic signed [23:0] operand_value;
	logic seg_valid;
	logic seg_stall;
	logic [1:0] status;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic [7:0] segment_color;
	logic cfg_valid;
	logic cfg_ready;
	logic [tsg_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	pose_t pose;
	pose_t saved_poses [0:STACK_LEVELS-1];
	int stack_used;
	tsg_pkg::heading_t start_heading_reg;
	tsg_pkg::heading_t turn_reg;
	longint quarter_sine [0:1024];

	seg_word_t segments_due [$];
	row_t directed_plan [$];
	int errors = 0;
	int items_sent = 0;
	bit calm = 1'b0;
	bit gaps_on = 1'b1;
	int hold_asks = 0;

	turtle_segment_generator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.opcode(opcode),
		.operand_value(operand_value),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.status(status),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.segment_color(segment_color),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint round_q16(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic longint wave(logic [11:0] h);
		longint m;
		m = h[10] ? quarter_sine[1024 - int'(h[9:0])] : quarter_sine[int'(h[9:0])];
		return h[11] ? -m : m;
	endfunction

	task automatic restart_pose();
		pose.heading = start_heading_reg;
		pose.px = 0;
		pose.py = 0;
		pose.step = int'(tsg_pkg::STEP_ONE);
		pose.neg = 1'b0;
		pose.color = 8'd0;
		stack_used = 0;
	endtask

	task automatic advance_pose();
		logic [11:0] h12;
		longint c;
		longint s;
		h12 = pose.heading[tsg_pkg::ANGLE_BITS-1 -: 12];
		c = wave(h12 + 12'd1024);
		s = wave(h12);
		pose.px = clamp32(longint'(pose.px) + round_q16(longint'(pose.step) * c));
		pose.py = clamp32(longint'(pose.py) + round_q16(longint'(pose.step) * s));
	endtask

	task automatic predict_command(input logic [3:0] op, input logic [23:0] arg,
			output bit emits, output seg_word_t word);
		longint val;
		longint deg;
		longint inc;
		longint scaled;
		int x0;
		int y0;
		bit sub;
		val = $signed(arg);
		emits = 1'b0;
		word = NO_WORD;
		case (op)
			tsg_pkg::OP_START: restart_pose();
			tsg_pkg::OP_PLUS, tsg_pkg::OP_MINUS: begin
				sub = (op == tsg_pkg::OP_MINUS) != pose.neg;
				pose.heading = sub ? pose.heading - turn_reg : pose.heading + turn_reg;
			end
			tsg_pkg::OP_MOVE: advance_pose();
			tsg_pkg::OP_DRAW: begin
				x0 = pose.px;
				y0 = pose.py;
				advance_pose();
				emits = 1'b1;
				word.status = tsg_pkg::STATUS_SEGMENT;
				word.sx = x0;
				word.sy = y0;
				word.ex = pose.px;
				word.ey = pose.py;
				word.color = pose.color;
			end
			tsg_pkg::OP_PUSH: begin
				if (stack_used < STACK_LEVELS) begin
					saved_poses[stack_used] = pose;
					stack_used++;
				end else begin
					emits = 1'b1;
					word.status = tsg_pkg::STATUS_OVERFLOW;
				end
			end
			tsg_pkg::OP_POP: begin
				if (stack_used > 0) begin
					stack_used--;
					pose = saved_poses[stack_used];
				end else begin
					emits = 1'b1;
					word.status = tsg_pkg::STATUS_UNDERFLOW;
				end
			end
			tsg_pkg::OP_REVERSE: pose.neg = !pose.neg;
			tsg_pkg::OP_SETCOL: pose.color = arg[7:0];
			tsg_pkg::OP_ADDCOL: pose.color = pose.color + arg[7:0];
			tsg_pkg::OP_SCALE: begin
				scaled = round_q16(longint'(pose.step) * val);
				if (scaled > 64'sd8388607) scaled = 64'sd8388607;
				if (scaled < -64'sd8388608) scaled = -64'sd8388608;
				pose.step = int'(scaled);
			end
			tsg_pkg::OP_TURNDEG: begin
				deg = pose.neg ? -val : val;
				deg = deg % FULL_CIRCLE;
				if (deg < 0) deg = deg + FULL_CIRCLE;
				inc = ((deg <<< tsg_pkg::ANGLE_BITS) + FULL_CIRCLE / 2) / FULL_CIRCLE;
				pose.heading = pose.heading + tsg_pkg::heading_t'(inc);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic compare_word();
		seg_word_t want;
		if (segments_due.size() == 0) begin
			report_mismatch("result word with nothing pending");
		end else begin
			want = segments_due.pop_front();
			if (status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
			if (start_x !== want.sx)
				report_mismatch($sformatf("start_x %0d, expected %0d", start_x, $signed(want.sx)));
			if (start_y !== want.sy)
				report_mismatch($sformatf("start_y %0d, expected %0d", start_y, $signed(want.sy)));
			if (end_x !== want.ex)
				report_mismatch($sformatf("end_x %0d, expected %0d", end_x, $signed(want.ex)));
			if (end_y !== want.ey)
				report_mismatch($sformatf("end_y %0d, expected %0d", end_y, $signed(want.ey)));
			if (segment_color !== want.color)
				report_mismatch($sformatf("segment_color %0d, expected %0d",
					segment_color, want.color));
		end
	endtask

	task automatic send_command(input logic [3:0] op, input logic [23:0] arg, input bit typed,
			input seg_word_t want);
		bit emits;
		seg_word_t word;
		if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= op;
		operand_value <= arg;
		do @(posedge clk); while (cmd_stall);
		predict_command(op, arg, emits, word);
		if (emits) segments_due.insert(segments_due.size(), typed ? want : word);
		if (op < OP_IGNORED_LO) items_sent++;
	endtask

	task automatic send_plain(input logic [3:0] op, input logic [23:0] arg);
		send_command(op, arg, 1'b0, NO_WORD);
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		while (segments_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [15:0] heading_val, input logic [15:0] angle_val);
		cfg_valid <= 1'b1;
		cfg_index <= tsg_pkg::CFG_INITIAL_HEADING;
		cfg_data <= heading_val;
		do @(posedge clk); while (!cfg_ready);
		start_heading_reg = heading_val;
		cfg_index <= tsg_pkg::CFG_TURN_ANGLE;
		cfg_data <= angle_val;
		do @(posedge clk); while (!cfg_ready);
		turn_reg = angle_val;
		cfg_valid <= 1'b0;
	endtask

	task automatic plan_row(input logic [3:0] op, input logic [23:0] arg);
		row_t row;
		row.op = op;
		row.arg = arg;
		row.typed = 1'b0;
		row.want = NO_WORD;
		directed_plan.insert(directed_plan.size(), row);
	endtask

	task automatic plan_typed(input logic [3:0] op, input logic [1:0] st, input logic [31:0] ex,
			input logic [31:0] sx);
		row_t row;
		row.op = op;
		row.arg = 24'd0;
		row.typed = 1'b1;
		row.want = NO_WORD;
		row.want.status = st;
		row.want.sx = sx;
		row.want.ex = ex;
		directed_plan.insert(directed_plan.size(), row);
	endtask

	task automatic random_command();
		int f;
		case ($urandom_range(0, 9))
			0: send_plain(4'($urandom_range(0, 15)), 24'($urandom));
			1: send_plain($urandom_range(0, 1) ? tsg_pkg::OP_PLUS : tsg_pkg::OP_MINUS,
				24'($urandom));
			2: begin
				if ($urandom_range(0, 1))
					send_plain(tsg_pkg::OP_TURNDEG, 24'($urandom_range(0, 720) - 360));
				else
					send_plain(tsg_pkg::OP_TURNDEG, 24'($urandom));
			end
			3, 4: send_plain(tsg_pkg::OP_DRAW, 24'($urandom));
			5: send_plain(tsg_pkg::OP_MOVE, 24'($urandom));
			6: send_plain($urandom_range(0, 1) ? tsg_pkg::OP_SETCOL : tsg_pkg::OP_ADDCOL,
				24'($urandom));
			7: begin
				f = $urandom_range(16384, 131072);
				if ($urandom_range(0, 7) == 0) f = -f;
				send_plain(tsg_pkg::OP_SCALE, 24'(f));
			end
			8: send_plain(tsg_pkg::OP_REVERSE, 24'($urandom));
			default: send_plain($urandom_range(0, 1) ? tsg_pkg::OP_PUSH : tsg_pkg::OP_POP,
				24'($urandom));
		endcase
	endtask

	task automatic fill_stack();
		int n;
		n = STACK_LEVELS - stack_used + $urandom_range(0, 2);
		repeat (n) begin
			send_plain(tsg_pkg::OP_PUSH, 24'($urandom));
			if ($urandom_range(0, 3) == 0) send_plain(tsg_pkg::OP_PLUS, 24'($urandom));
		end
		n = stack_used + $urandom_range(0, 2);
		repeat (n) begin
			send_plain(tsg_pkg::OP_POP, 24'($urandom));
			if ($urandom_range(0, 3) == 0) send_plain(tsg_pkg::OP_DRAW, 24'($urandom));
		end
	endtask

	task automatic random_burst();
		int pick;
		gaps_on = ($urandom_range(0, 3) != 0);
		pick = $urandom_range(0, 149);
		if (pick == 0) begin
			fill_stack();
		end else if (pick < 10) begin
			send_plain(tsg_pkg::OP_START, 24'($urandom));
		end else if (pick < 55) begin
			random_command();
		end else if (pick < 110) begin
			send_plain(tsg_pkg::OP_PUSH, 24'($urandom));
			repeat ($urandom_range(1, 6)) random_command();
			send_plain(tsg_pkg::OP_POP, 24'($urandom));
		end else begin
			repeat ($urandom_range(2, 8)) begin
				send_plain(tsg_pkg::OP_DRAW, 24'($urandom));
				if ($urandom_range(0, 1))
					send_plain(tsg_pkg::OP_TURNDEG, 24'($urandom_range(0, 359)));
				else
					send_plain(tsg_pkg::OP_PLUS, 24'($urandom));
			end
		end
	endtask

	initial begin : result_side
		int burst_left;
		int hold_left;
		int hold_seen;
		bit sink_quiet;
		burst_left = 0;
		hold_left = 0;
		hold_seen = 0;
		sink_quiet = 1'b0;
		seg_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && seg_valid && !seg_stall) compare_word();
			if ($urandom_range(0, 99) == 0) sink_quiet = !sink_quiet;
			if (hold_asks != hold_seen) begin
				hold_left = HOLD_CYCLES;
				hold_seen = hold_asks;
			end
			if (hold_left > 0) begin
				hold_left--;
				seg_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				seg_stall <= 1'b1;
			end else if (!calm && !sink_quiet && $urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(1, 8) - 1;
				seg_stall <= 1'b1;
			end else begin
				seg_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (seg_valid && !seg_stall)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : command_side
		longint t;
		longint t2;
		longint p;
		longint s;
		int goal;
		bit paused;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		opcode <= tsg_pkg::OP_START;
		operand_value <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= tsg_pkg::CFG_INITIAL_HEADING;
		cfg_data <= '0;

		// Quarter-wave sine in Q1.16, odd polynomial in Horner form, clamped at 1.0.
		for (int k = 0; k <= 1024; k++) begin
			t = longint'(k) <<< 20;
			t2 = (t * t) >>> 30;
			p = 64'sd172272;
			p = 64'sd5026998 - ((t2 * p) >>> 30);
			p = 64'sd85569305 - ((t2 * p) >>> 30);
			p = 64'sd693598668 - ((t2 * p) >>> 30);
			p = 64'sd1686629713 - ((t2 * p) >>> 30);
			s = (((t * p) >>> 30) + 64'sd8192) >>> 14;
			quarter_sine[k] = (s > 64'sd65536) ? 64'sd65536 : s;
		end

		start_heading_reg = '0;
		turn_reg = '0;
		restart_pose();

		plan_typed(tsg_pkg::OP_POP, tsg_pkg::STATUS_UNDERFLOW, 32'd0, 32'd0);
		plan_typed(tsg_pkg::OP_DRAW, tsg_pkg::STATUS_SEGMENT, 32'd65536, 32'd0);
		plan_row(tsg_pkg::OP_SETCOL, 24'h7FFFFF);
		plan_row(tsg_pkg::OP_ADDCOL, 24'h000001);
		plan_typed(tsg_pkg::OP_DRAW, tsg_pkg::STATUS_SEGMENT, 32'd131072, 32'd65536);
		plan_row(tsg_pkg::OP_ADDCOL, 24'h800000);
		plan_row(tsg_pkg::OP_TURNDEG, 24'd90);
		plan_row(tsg_pkg::OP_DRAW, 24'h000000);
		plan_row(tsg_pkg::OP_PLUS, 24'h000000);
		plan_row(tsg_pkg::OP_REVERSE, 24'h000000);
		plan_row(tsg_pkg::OP_MINUS, 24'hFFFFFF);
		plan_row(tsg_pkg::OP_MOVE, 24'h000000);
		plan_row(tsg_pkg::OP_TURNDEG, 24'hFFFFFF);
		plan_row(tsg_pkg::OP_TURNDEG, 24'h7FFFFF);
		plan_row(tsg_pkg::OP_TURNDEG, 24'h800000);
		plan_row(tsg_pkg::OP_REVERSE, 24'h000000);
		plan_row(tsg_pkg::OP_SCALE, 24'h7FFFFF);
		plan_row(tsg_pkg::OP_DRAW, 24'h000000);
		plan_row(tsg_pkg::OP_SCALE, 24'h800000);
		plan_row(tsg_pkg::OP_PUSH, 24'h000000);
		plan_row(tsg_pkg::OP_DRAW, 24'h000000);
		plan_row(tsg_pkg::OP_POP, 24'h000000);
		plan_row(OP_IGNORED_LO, 24'h555555);
		plan_row(OP_IGNORED_HI, 24'hAAAAAA);
		plan_row(tsg_pkg::OP_START, 24'h000000);
		plan_typed(tsg_pkg::OP_POP, tsg_pkg::STATUS_UNDERFLOW, 32'd0, 32'd0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_config(16'h0000, 16'hFFFF);
		foreach (directed_plan[i])
			send_command(directed_plan[i].op, directed_plan[i].arg, directed_plan[i].typed,
				directed_plan[i].want);
		settle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_config(16'hFFFF, 16'h0000);
				1: write_config(16'h0000, 16'($urandom));
				2: write_config(16'($urandom), 16'hFFFF);
				default: write_config(16'($urandom), 16'($urandom));
			endcase
			calm = (phase == 3);
			paused = 1'b0;
			send_plain(tsg_pkg::OP_START, 24'($urandom));
			if (phase == 0) begin
				hold_asks++;
				fill_stack();
			end
			if (phase == 1) begin
				// Walk along an axis at the largest step until both ends of the segments saturate.
				send_plain(tsg_pkg::OP_SCALE, 24'h7FFFFF);
				send_plain(tsg_pkg::OP_TURNDEG, 24'($urandom_range(0, 3) * 90));
				for (int k = 0; k < 280; k++)
					send_plain((k % 8 == 7) ? tsg_pkg::OP_DRAW : tsg_pkg::OP_MOVE,
						24'($urandom));
				send_plain(tsg_pkg::OP_START, 24'($urandom));
			end
			goal = items_sent + 340;
			while (items_sent < goal) begin
				if (phase == 2 && !paused && items_sent > goal - 170) begin
					settle();
					paused = 1'b1;
				end
				random_burst();
			end
			settle();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/tsg_pkg.sv
rtl/tsg_trig_rom.sv
rtl/tsg_stack.sv
rtl/tsg_exec.sv
rtl/turtle_segment_generator_core.sv
tb/tb_turtle_segment_generator_core.sv
